>>> src/tbr_pkg.sv
`timescale 1ns / 1ps

package tbr_pkg;

  localparam int unsigned NumSlotsDef  = 8;
  localparam int unsigned CountBitsDef = 16;

  localparam logic [15:0] DefaultPeriod = 16'd10;
  localparam logic [15:0] PendingMax    = 16'hFFFF;
  localparam logic [3:0]  ExpiriesMax   = 4'd15;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SETUP   = 2'd1,
    OP_START   = 2'd2,
    OP_SERVICE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TICK,
    BK_SVC
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  slot;
    logic        slot_ok;
    logic [15:0] period;
    logic        one_shot;
  } cmd_t;

endpackage

>>> src/tbr_ram.sv
`timescale 1ns / 1ps

module tbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/tbr_front.sv
`timescale 1ns / 1ps

module tbr_front import tbr_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  slot_index_i,
  input  logic [15:0] period_i,
  input  logic        one_shot_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  localparam int unsigned PerLim = (COUNT_BITS >= 16) ? 65535 : ((1 << COUNT_BITS) - 1);
  localparam logic [15:0] PerLimW = 16'(PerLim);
  localparam logic [6:0]  NumSlotsW = 7'(NUM_SLOTS);

  cmd_t        entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  cmd_t        cmd;
  logic [15:0] per_nz;

  assign busy_o = (count_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_comb begin
    per_nz       = (period_i == 16'd0) ? DefaultPeriod : period_i;
    cmd.op       = op_e'(opcode_i);
    cmd.slot     = slot_index_i;
    cmd.slot_ok  = ({4'b0000, slot_index_i} < NumSlotsW);
    cmd.period   = (per_nz > PerLimW) ? PerLimW : per_nz;
    cmd.one_shot = one_shot_i;
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

>>> src/tbr_back.sv
`timescale 1ns / 1ps

module tbr_back import tbr_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        valid_o,
  output logic        fired_o,
  output logic [2:0]  fired_index_o,
  output logic [3:0]  new_expiries_o,
  output logic [15:0] pending_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned HitW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned RamW  = 2 * COUNT_BITS;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_SLOTS - 1);

  back_state_e state_q, state_d;

  logic [SlotW-1:0]  cur_q, cur_d;
  logic [SlotW-1:0]  step_q, step_d;
  logic [SlotW-1:0]  last_q, last_d;
  logic              last_valid_q, last_valid_d;
  logic [15:0]       pending_q, pending_d;
  logic [HitW-1:0]   hits_q, hits_d;
  logic [NUM_SLOTS-1:0] running_q, running_d;
  logic [NUM_SLOTS-1:0] one_shot_q, one_shot_d;
  logic [NUM_SLOTS-1:0] in_use_q, in_use_d;

  logic              res_valid_q, res_valid_d;
  logic              fired_q, fired_d;
  logic [2:0]        fidx_q, fidx_d;
  logic [3:0]        nexp_q, nexp_d;

  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [RamW-1:0]   ram_wdata;
  logic [SlotW-1:0]  ram_raddr;
  logic [RamW-1:0]   ram_rdata;

  logic [COUNT_BITS-1:0] rd_count, rd_period, count_inc;
  logic [SlotW+2:0]      slot_ext, cur_ext;
  logic [SlotW-1:0]      slot_w, cur_nxt, svc_start;
  logic [COUNT_BITS+15:0] per_ext;
  logic [COUNT_BITS-1:0] per_w;
  logic [HitW-1:0]       hits_sum;
  logic [HitW+3:0]       hits_ext;
  logic [3:0]            hits_sat;
  logic                  tick_adv, tick_hit, svc_hit, step_last, pending_zero;

  tbr_ram #(
    .WIDTH (RamW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_count  = ram_rdata[RamW-1:COUNT_BITS];
  assign rd_period = ram_rdata[COUNT_BITS-1:0];
  assign count_inc = rd_count + 1'b1;

  assign slot_ext = {{SlotW{1'b0}}, q_cmd_i.slot};
  assign slot_w   = slot_ext[SlotW-1:0];
  assign per_ext  = {{COUNT_BITS{1'b0}}, q_cmd_i.period};
  assign per_w    = per_ext[COUNT_BITS-1:0];
  assign cur_ext  = {3'b000, cur_q};

  assign cur_nxt   = (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
  assign svc_start = !last_valid_q ? '0 : ((last_q == LastSlot) ? '0 : last_q + 1'b1);

  assign tick_adv  = in_use_q[cur_q] && running_q[cur_q] && (rd_count < rd_period);
  assign tick_hit  = tick_adv && (count_inc == rd_period);
  assign svc_hit   = in_use_q[cur_q] && (rd_count == rd_period);
  assign step_last = (step_q == LastSlot);
  assign pending_zero = (pending_q == 16'd0);

  assign hits_sum = hits_q + {{(HitW-1){1'b0}}, tick_hit};
  assign hits_ext = {4'b0000, hits_sum};
  assign hits_sat = (hits_ext > (HitW+4)'(ExpiriesMax)) ? ExpiriesMax : hits_ext[3:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.op == OP_TICK) begin
            state_d = BK_TICK;
          end else if (q_cmd_i.op == OP_SERVICE && !pending_zero) begin
            state_d = BK_SVC;
          end
        end
      end
      BK_TICK: begin
        if (step_last) begin
          state_d = BK_IDLE;
        end
      end
      BK_SVC: begin
        if (svc_hit || step_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = 1'b0;
    cur_d        = cur_q;
    step_d       = step_q;
    last_d       = last_q;
    last_valid_d = last_valid_q;
    pending_d    = pending_q;
    hits_d       = hits_q;
    running_d    = running_q;
    one_shot_d   = one_shot_q;
    in_use_d     = in_use_q;
    res_valid_d  = 1'b0;
    fired_d      = 1'b0;
    fidx_d       = 3'd0;
    nexp_d       = 4'd0;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = {rd_count, rd_period};
    ram_raddr    = cur_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.op)
            OP_TICK: begin
              cur_d     = '0;
              step_d    = '0;
              hits_d    = '0;
              ram_raddr = '0;
            end
            OP_SETUP: begin
              res_valid_d = 1'b1;
              if (q_cmd_i.slot_ok) begin
                ram_we             = 1'b1;
                ram_waddr          = slot_w;
                ram_wdata          = {{COUNT_BITS{1'b0}}, per_w};
                one_shot_d[slot_w] = q_cmd_i.one_shot;
                running_d[slot_w]  = 1'b0;
                in_use_d[slot_w]   = 1'b1;
              end
            end
            OP_START: begin
              res_valid_d = 1'b1;
              if (q_cmd_i.slot_ok && in_use_q[slot_w]) begin
                running_d[slot_w] = 1'b1;
              end
            end
            OP_SERVICE: begin
              if (pending_zero) begin
                res_valid_d = 1'b1;
              end else begin
                pending_d = pending_q - 16'd1;
                cur_d     = svc_start;
                step_d    = '0;
                ram_raddr = svc_start;
              end
            end
            default: ;
          endcase
        end
      end
      BK_TICK: begin
        ram_raddr = cur_nxt;
        if (tick_adv) begin
          ram_we    = 1'b1;
          ram_wdata = {count_inc, rd_period};
        end
        if (tick_hit && pending_q != PendingMax) begin
          pending_d = pending_q + 16'd1;
        end
        hits_d = hits_sum;
        cur_d  = cur_nxt;
        step_d = step_q + 1'b1;
        if (step_last) begin
          res_valid_d = 1'b1;
          nexp_d      = hits_sat;
        end
      end
      BK_SVC: begin
        ram_raddr = cur_nxt;
        if (svc_hit) begin
          ram_we       = 1'b1;
          ram_wdata    = {{COUNT_BITS{1'b0}}, rd_period};
          last_d       = cur_q;
          last_valid_d = 1'b1;
          res_valid_d  = 1'b1;
          fired_d      = 1'b1;
          fidx_d       = cur_ext[2:0];
          if (one_shot_q[cur_q]) begin
            running_d[cur_q] = 1'b0;
          end
        end else begin
          cur_d  = cur_nxt;
          step_d = step_q + 1'b1;
          if (step_last) begin
            res_valid_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      cur_q        <= '0;
      step_q       <= '0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      pending_q    <= 16'd0;
      hits_q       <= '0;
      running_q    <= '0;
      one_shot_q   <= '0;
      in_use_q     <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      step_q       <= step_d;
      last_q       <= last_d;
      last_valid_q <= last_valid_d;
      pending_q    <= pending_d;
      hits_q       <= hits_d;
      running_q    <= running_d;
      one_shot_q   <= one_shot_d;
      in_use_q     <= in_use_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q <= fired_d;
    fidx_q  <= fidx_d;
    nexp_q  <= nexp_d;
  end

  assign valid_o        = res_valid_q;
  assign fired_o        = fired_q;
  assign fired_index_o  = fidx_q;
  assign new_expiries_o = nexp_q;
  assign pending_o      = pending_q;

endmodule

>>> src/timer_bank_round_robin_expiry.sv
`timescale 1ns / 1ps
// Channel   Handshake              Word
// command   start_i / busy_o       opcode_i, slot_index_i, period_i, one_shot_i
// result    valid_o (one cycle)    fired_o, fired_index_o, new_expiries_o, pending_o
//
// Commands enter a two-entry queue and are executed one at a time by the back end.
// Setup, start and a service with nothing pending finish in the idle state. A tick
// visits every slot; a service starts after the last slot served and stops at the
// first expired slot or after all slots, since the slot RAM is scanned one slot per
// cycle through its single read port. Results are registered; busy_o is high while
// the queue is full. Reset stops all slots at once, with no clearing pass.

module timer_bank_round_robin_expiry import tbr_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = NumSlotsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  slot_index_i,
  input  logic [15:0] period_i,
  input  logic        one_shot_i,
  output logic        valid_o,
  output logic        fired_o,
  output logic [2:0]  fired_index_o,
  output logic [3:0]  new_expiries_o,
  output logic [15:0] pending_o
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  tbr_front #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .slot_index_i (slot_index_i),
    .period_i     (period_i),
    .one_shot_i   (one_shot_i),
    .q_valid_o    (q_valid),
    .q_cmd_o      (q_cmd),
    .q_pop_i      (q_pop)
  );

  tbr_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .valid_o        (valid_o),
    .fired_o        (fired_o),
    .fired_index_o  (fired_index_o),
    .new_expiries_o (new_expiries_o),
    .pending_o      (pending_o)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_fire_not_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && new_expiries_o != 4'd0) |-> !fired_o)
    else $error("tick word reports a fired slot");

  a_index_zero_unfired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !fired_o) |-> (fired_index_o == 3'd0))
    else $error("fired index set without a fire");

  a_pending_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_o < $past(pending_o)) |-> (pending_o == $past(pending_o) - 16'd1))
    else $error("pending count dropped by more than one");

endmodule

>>> tb/timer_bank_round_robin_expiry_tb.sv
`timescale 1ns / 1ps

module timer_bank_round_robin_expiry_tb;
  import tbr_pkg::*;

  localparam int unsigned Slots = NumSlotsDef;

  typedef struct packed {
    logic        fired;
    logic [2:0]  fired_index;
    logic [3:0]  new_expiries;
    logic [15:0] pending;
  } bank_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [2:0]  slot_index_i;
  logic [15:0] period_i;
  logic        one_shot_i;
  logic        valid_o;
  logic        fired_o;
  logic [2:0]  fired_index_o;
  logic [3:0]  new_expiries_o;
  logic [15:0] pending_o;

  logic [15:0] slot_ticks    [Slots];
  logic [15:0] slot_period   [Slots];
  logic        slot_one_shot [Slots];
  logic        slot_running  [Slots];
  logic        slot_in_use   [Slots];
  logic [2:0]  served_slot;
  logic        served_ok;
  logic [15:0] pend_total;

  bank_word_t awaited_words[$];
  int         fault_count;

  timer_bank_round_robin_expiry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .slot_index_i  (slot_index_i),
    .period_i      (period_i),
    .one_shot_i    (one_shot_i),
    .valid_o       (valid_o),
    .fired_o       (fired_o),
    .fired_index_o (fired_index_o),
    .new_expiries_o(new_expiries_o),
    .pending_o     (pending_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bank_word_t compute_bank_response(op_e op, logic [2:0] slot,
                                                       logic [15:0] per, logic shot);
    bank_word_t w;
    int         hits;
    logic [2:0] first;
    logic [2:0] s;
    logic       found;
    w = '0;
    hits = 0;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_in_use[i] && slot_running[i] && slot_ticks[i] < slot_period[i]) begin
            slot_ticks[i] = slot_ticks[i] + 16'd1;
            if (slot_ticks[i] == slot_period[i]) begin
              hits++;
              if (pend_total != PendingMax) pend_total = pend_total + 16'd1;
            end
          end
        end
        w.new_expiries = (hits > ExpiriesMax) ? ExpiriesMax : 4'(hits);
      end
      OP_SETUP: begin
        slot_period[slot]   = (per == 16'd0) ? DefaultPeriod : per;
        slot_one_shot[slot] = shot;
        slot_ticks[slot]    = 16'd0;
        slot_running[slot]  = 1'b0;
        slot_in_use[slot]   = 1'b1;
      end
      OP_START: begin
        if (slot_in_use[slot]) slot_running[slot] = 1'b1;
      end
      default: begin
        if (pend_total != 16'd0) begin
          pend_total = pend_total - 16'd1;
          first = served_ok ? served_slot + 3'd1 : 3'd0;
          for (int k = 0; k < Slots; k++) begin
            s = 3'(first + k);
            if (!found && slot_in_use[s] && slot_ticks[s] == slot_period[s]) begin
              found = 1'b1;
              slot_ticks[s] = 16'd0;
              if (slot_one_shot[s]) slot_running[s] = 1'b0;
              served_slot = s;
              served_ok = 1'b1;
              w.fired = 1'b1;
              w.fired_index = s;
            end
          end
        end
      end
    endcase
    w.pending = pend_total;
    return w;
  endfunction

  task automatic send_word(input op_e op, input logic [2:0] slot, input logic [15:0] per,
                           input logic shot);
    @(negedge clk_i);
    start_i      = 1'b1;
    opcode_i     = op;
    slot_index_i = slot;
    period_i     = per;
    one_shot_i   = shot;
    do @(posedge clk_i); while (busy_o);
    awaited_words.push_back(compute_bank_response(op, slot, per, shot));
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  task automatic wait_results_drained(input int limit);
    int n;
    n = 0;
    hold_off(1);
    while (awaited_words.size() != 0 && n < limit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    int          r;
    logic [15:0] per;
    r = $urandom_range(99);
    per = 16'($urandom_range(65535));
    if (r < 40) begin
      send_word(OP_TICK, 3'($urandom_range(7)), per, 1'($urandom_range(1)));
    end else if (r < 62) begin
      send_word(OP_SERVICE, 3'($urandom_range(7)), per, 1'($urandom_range(1)));
    end else if (r < 82) begin
      r = $urandom_range(99);
      if (r < 70) per = 16'($urandom_range(12));
      else if (r < 90) per = 16'($urandom_range(60));
      send_word(OP_SETUP, 3'($urandom_range(7)), per, 1'($urandom_range(1)));
    end else begin
      send_word(OP_START, 3'($urandom_range(7)), per, 1'($urandom_range(1)));
    end
  endtask

  always @(posedge clk_i) begin : check_words
    bank_word_t want;
    if (rst_ni && valid_o) begin
      if (awaited_words.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected word: fired=%0d index=%0d new=%0d pending=%0d",
                   fired_o, fired_index_o, new_expiries_o, pending_o);
      end else begin
        want = awaited_words.pop_front();
        if (fired_o !== want.fired || fired_index_o !== want.fired_index ||
            new_expiries_o !== want.new_expiries || pending_o !== want.pending) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected fired=%0d index=%0d new=%0d pending=%0d",
                     want.fired, want.fired_index, want.new_expiries, want.pending);
            $display("          got      fired=%0d index=%0d new=%0d pending=%0d",
                     fired_o, fired_index_o, new_expiries_o, pending_o);
          end
        end
      end
    end
  end

  task automatic test_after_reset();
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_TICK, 3'd7, 16'hFFFF, 1'b1);
    send_word(OP_START, 3'd5, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd7, 16'hFFFF, 1'b1);
  endtask

  task automatic test_setup_start_service();
    send_word(OP_SETUP, 3'd0, 16'd0, 1'b0);
    send_word(OP_SETUP, 3'd7, 16'hFFFF, 1'b1);
    send_word(OP_SETUP, 3'd3, 16'd1, 1'b1);
    send_word(OP_SETUP, 3'd4, 16'd1, 1'b0);
    send_word(OP_START, 3'd0, 16'd0, 1'b0);
    send_word(OP_START, 3'd3, 16'd0, 1'b0);
    send_word(OP_START, 3'd4, 16'd0, 1'b0);
    send_word(OP_START, 3'd7, 16'd0, 1'b0);
    send_word(OP_START, 3'd6, 16'd0, 1'b0);
    send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
    send_word(OP_SETUP, 3'd4, 16'd2, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    repeat (8) send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
  endtask

  task automatic test_pause_until_drained();
    repeat (20) send_random_word();
    wait_results_drained(2000);
    repeat (20) send_random_word();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    repeat (count) begin
      send_random_word();
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) hold_off($urandom_range(1, 12));
      if ($urandom_range(99) < 2) wait_results_drained(2000);
    end
  endtask

  task automatic test_pending_burst();
    repeat (6) begin
      for (int s = 0; s < Slots; s++) begin
        send_word(OP_SETUP, 3'(s), 16'd1, 1'b0);
        send_word(OP_START, 3'(s), 16'd0, 1'b0);
      end
      send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
    end
    for (int s = 0; s < Slots; s++) begin
      send_word(OP_SETUP, 3'(s), 16'd1, 1'b1);
      send_word(OP_START, 3'(s), 16'd0, 1'b0);
    end
    send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_SERVICE, 3'd0, 16'd0, 1'b0);
    send_word(OP_TICK, 3'd0, 16'd0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_ticks[i]    = 16'd0;
      slot_period[i]   = 16'd0;
      slot_one_shot[i] = 1'b0;
      slot_running[i]  = 1'b0;
      slot_in_use[i]   = 1'b0;
    end
    served_slot  = 3'd0;
    served_ok    = 1'b0;
    pend_total   = 16'd0;
    fault_count  = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    opcode_i     = OP_TICK;
    slot_index_i = 3'd0;
    period_i     = 16'd0;
    one_shot_i   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_setup_start_service();
    test_pause_until_drained();
    test_random_traffic(300, 0);
    test_random_traffic(300, 58);
    test_random_traffic(300, 18);
    test_random_traffic(270, 0);
    wait_results_drained(2000);
    test_pending_burst();
    wait_results_drained(2000);

    if (fault_count == 0 && awaited_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
